// ===== hw/rtl/reflection_vector_unit_defines.svh =====
// assertion macros for the reflection vector unit
// no dependencies; taken in by files that carry concurrent checks
`ifndef REFLECTION_VECTOR_UNIT_DEFINES_SVH
`define REFLECTION_VECTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is low
`define RVU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, disabled while reset is low
`define RVU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RVU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RVU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rvu_pkg.sv =====
// shared widths, stage counts and types of the reflection vector unit
// no dependencies; used by the interfaces, the normaliser and the top level
`timescale 1ns / 1ps
package rvu_pkg;

	localparam int IN_WIDTH      = 16;
	localparam int OUT_FRAC_BITS = 14;
	localparam int REFL_WIDTH    = 16;

	// magnitude of a component, the most negative code included
	localparam int MAG_W = IN_WIDTH;
	localparam int POS_W = $clog2(MAG_W);
	// prescaled magnitudes have their largest member in [2^14, 2^15)
	localparam int PRE_W = 15;
	// sum of three squares of prescaled magnitudes
	localparam int SUM_W = 2 * PRE_W + 2;
	// square root taken of sum * 2^(2*SQRT_FRAC)
	localparam int SQRT_FRAC = 16;
	localparam int SQ_BITS   = SUM_W / 2 + SQRT_FRAC;
	// unit magnitude never exceeds 1.0
	localparam int QUO_W  = OUT_FRAC_BITS + 1;
	localparam int UNIT_W = OUT_FRAC_BITS + 2;

	// normaliser: abs, prescale, square, sum, root bits, numerator, quotient bits, sign
	localparam int NORM_LAT = 4 + SQ_BITS + 1 + QUO_W + 1;
	// dot products, dot sum, dot rounding, scale by normal, rounding
	localparam int POST_LAT = 5;
	localparam int PIPE_LAT = NORM_LAT + POST_LAT;

	localparam int HALF = 1 << (OUT_FRAC_BITS - 1);

	typedef logic signed [IN_WIDTH-1:0]   comp_t;
	typedef logic signed [UNIT_W-1:0]     unit_t;
	typedef logic signed [REFL_WIDTH-1:0] refl_t;

	// pipeline control shared by the normalisers and the top level
	typedef struct packed {
		logic en;
	} pipe_ctrl_t;

endpackage

// ===== hw/rtl/rvu_vec_if.sv =====
// input channel of the reflection vector unit: normal and light vectors
// depends on rvu_pkg
`timescale 1ns / 1ps
interface rvu_vec_if;

	logic          valid;
	logic          ready;
	rvu_pkg::comp_t normal_x;
	rvu_pkg::comp_t normal_y;
	rvu_pkg::comp_t normal_z;
	rvu_pkg::comp_t light_x;
	rvu_pkg::comp_t light_y;
	rvu_pkg::comp_t light_z;

	modport source (
		output valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
		input  ready
	);

	modport sink (
		input  valid, normal_x, normal_y, normal_z, light_x, light_y, light_z,
		output ready
	);

endinterface

// ===== hw/rtl/rvu_refl_if.sv =====
// output channel of the reflection vector unit: reflected vector and flag
// depends on rvu_pkg
`timescale 1ns / 1ps
interface rvu_refl_if;

	logic          valid;
	logic          ready;
	rvu_pkg::refl_t refl_x;
	rvu_pkg::refl_t refl_y;
	rvu_pkg::refl_t refl_z;
	logic          degenerate;

	modport source (
		output valid, refl_x, refl_y, refl_z, degenerate,
		input  ready
	);

	modport sink (
		input  valid, refl_x, refl_y, refl_z, degenerate,
		output ready
	);

endinterface

// ===== hw/rtl/reflection_vector_unit.sv =====
// reflection vector unit top level; depends on rvu_pkg, rvu_norm and the channel interfaces
// an accepted item passes through the normalisers, the later stages and the output register
// throughput: one item per cycle while the skid is empty, set by the pipelined square root
//   (one root bit per stage) and divider (one quotient bit per stage) in each normaliser
// stalls: a one-item skid register lets the output wait while the pipeline keeps its items
// reset: clears the valid bits, the output valid and the skid flag; no data path is reset
`timescale 1ns / 1ps
`include "reflection_vector_unit_defines.svh"
module reflection_vector_unit (
	input logic        clk,
	input logic        arst_n,
	rvu_vec_if.sink    vectors,
	rvu_refl_if.source reflection
);

	// widths of the dot product and reflection arithmetic
	localparam int PROD_W = 2 * rvu_pkg::UNIT_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int D_W    = DOT_W - rvu_pkg::OUT_FRAC_BITS;
	localparam int DN_W   = D_W + rvu_pkg::UNIT_W;
	localparam int T2_W   = DN_W + 1;
	localparam int T_W    = T2_W - rvu_pkg::OUT_FRAC_BITS;
	localparam int DIFF_W = T_W + 1;
	localparam int REFL_MAX = (1 << (rvu_pkg::REFL_WIDTH - 1)) - 1;
	localparam int REFL_MIN = -(1 << (rvu_pkg::REFL_WIDTH - 1));

	typedef struct packed {
		rvu_pkg::refl_t x;
		rvu_pkg::refl_t y;
		rvu_pkg::refl_t z;
		logic           deg;
	} result_t;

	rvu_pkg::pipe_ctrl_t ctrl;

	// valid bit of every pipeline stage, oldest at the top
	logic [rvu_pkg::PIPE_LAT-1:0] valid_s;

	rvu_pkg::comp_t nvec [3];
	rvu_pkg::comp_t lvec [3];
	rvu_pkg::unit_t nu [3];
	rvu_pkg::unit_t lu [3];
	logic           nzero, lzero;

	// stages after the normalisers
	logic signed [PROD_W-1:0] prod_s54 [3];
	rvu_pkg::unit_t           nu_s54 [3], nu_s55 [3], nu_s56 [3];
	rvu_pkg::unit_t           lu_s54 [3], lu_s55 [3], lu_s56 [3], lu_s57 [3], lu_s58 [3];
	logic                     deg_s54, deg_s55, deg_s56, deg_s57, deg_s58;
	logic signed [DOT_W-1:0]  dot_s55;
	logic signed [D_W-1:0]    d_s56;
	logic signed [DN_W-1:0]   dn_s57 [3];
	logic signed [T_W-1:0]    t_s58 [3];

	logic signed [DOT_W-1:0]  dot_rnd;
	logic signed [T2_W-1:0]   t2 [3];
	logic signed [T2_W-1:0]   t_rnd [3];
	logic signed [DIFF_W-1:0] diff [3];
	rvu_pkg::refl_t           sat [3];

	// output register and skid
	result_t res, out_q, skid_q;
	logic    out_valid_q, skid_full_q;
	logic    fin_valid, out_take, load_out_pipe, load_skid;

	// whole pipeline advances while the skid is empty
	assign ctrl.en        = !skid_full_q;
	assign vectors.ready  = ctrl.en;

	always_comb begin
		nvec[0] = vectors.normal_x;
		nvec[1] = vectors.normal_y;
		nvec[2] = vectors.normal_z;
		lvec[0] = vectors.light_x;
		lvec[1] = vectors.light_y;
		lvec[2] = vectors.light_z;
	end

	rvu_norm u_norm_n (
		.clk      (clk),
		.ctrl     (ctrl),
		.comp     (nvec),
		.unit_vec (nu),
		.zero     (nzero)
	);

	rvu_norm u_norm_l (
		.clk      (clk),
		.ctrl     (ctrl),
		.comp     (lvec),
		.unit_vec (lu),
		.zero     (lzero)
	);

	// rounding half away from zero: add half, less one for negatives, then floor
	always_comb begin
		dot_rnd = dot_s55 + DOT_W'(rvu_pkg::HALF) - DOT_W'(dot_s55[DOT_W-1]);
		for (int i = 0; i < 3; i++) begin
			t2[i]    = {dn_s57[i], 1'b0};
			t_rnd[i] = t2[i] + T2_W'(rvu_pkg::HALF) - T2_W'(t2[i][T2_W-1]);
		end
	end

	// subtract the light vector and clamp into the output range
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i] = DIFF_W'(t_s58[i]) - DIFF_W'(lu_s58[i]);
			if (diff[i] > DIFF_W'(REFL_MAX)) begin
				sat[i] = rvu_pkg::REFL_WIDTH'(REFL_MAX);
			end else if (diff[i] < DIFF_W'(REFL_MIN)) begin
				sat[i] = rvu_pkg::REFL_WIDTH'(REFL_MIN);
			end else begin
				sat[i] = rvu_pkg::REFL_WIDTH'(diff[i]);
			end
		end
		// zero vector on either side: direction undefined, result forced to zero
		res.deg = deg_s58;
		res.x   = deg_s58 ? '0 : sat[0];
		res.y   = deg_s58 ? '0 : sat[1];
		res.z   = deg_s58 ? '0 : sat[2];
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s54[i] <= nu[i] * lu[i];
			end
			nu_s54  <= nu;
			lu_s54  <= lu;
			deg_s54 <= nzero | lzero;

			dot_s55 <= DOT_W'(prod_s54[0]) + DOT_W'(prod_s54[1]) + DOT_W'(prod_s54[2]);
			nu_s55  <= nu_s54;
			lu_s55  <= lu_s54;
			deg_s55 <= deg_s54;

			d_s56   <= D_W'(dot_rnd >>> rvu_pkg::OUT_FRAC_BITS);
			nu_s56  <= nu_s55;
			lu_s56  <= lu_s55;
			deg_s56 <= deg_s55;

			for (int i = 0; i < 3; i++) begin
				dn_s57[i] <= d_s56 * nu_s56[i];
			end
			lu_s57  <= lu_s56;
			deg_s57 <= deg_s56;

			for (int i = 0; i < 3; i++) begin
				t_s58[i] <= T_W'(t_rnd[i] >>> rvu_pkg::OUT_FRAC_BITS);
			end
			lu_s58  <= lu_s57;
			deg_s58 <= deg_s57;
		end
	end

	assign fin_valid     = valid_s[rvu_pkg::PIPE_LAT-1];
	assign out_take      = out_valid_q && reflection.ready;
	// finished item goes straight to the output when it is free or being taken
	assign load_out_pipe = ctrl.en && fin_valid && (!out_valid_q || out_take);
	// otherwise it parks in the skid, which then stops the pipeline
	assign load_skid     = ctrl.en && fin_valid && out_valid_q && !out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s     <= '0;
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (ctrl.en) begin
				valid_s <= {valid_s[rvu_pkg::PIPE_LAT-2:0], vectors.valid};
			end
			if (skid_full_q) begin
				out_valid_q <= 1'b1;
				if (out_take) begin
					skid_full_q <= 1'b0;
				end
			end else begin
				if (!out_valid_q || out_take) begin
					out_valid_q <= fin_valid;
				end
				if (load_skid) begin
					skid_full_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_full_q && out_take) begin
			out_q <= skid_q;
		end else if (load_out_pipe) begin
			out_q <= res;
		end
		if (load_skid) begin
			skid_q <= res;
		end
	end

	assign reflection.valid      = out_valid_q;
	assign reflection.refl_x     = out_q.x;
	assign reflection.refl_y     = out_q.y;
	assign reflection.refl_z     = out_q.z;
	assign reflection.degenerate = out_q.deg;

	// a parked item always has an item ahead of it in the output register
	`RVU_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_full_q, out_valid_q, "skid full with output empty")

	// skid only fills when the output was holding an item that was not taken
	`RVU_ASSERT_IMP(a_skid_fill_cause, clk, arst_n, $rose(skid_full_q), $past(out_valid_q && !reflection.ready), "skid filled without a stalled output")

	// a frozen pipeline keeps every stage valid bit
	`RVU_ASSERT_NXT(a_freeze_holds, clk, arst_n, !ctrl.en, $stable(valid_s), "stage valid bits moved during a stall")

	// degenerate results carry a zero vector
	`RVU_ASSERT_IMP(a_degenerate_zero, clk, arst_n, reflection.valid && reflection.degenerate, (reflection.refl_x == '0) && (reflection.refl_y == '0) && (reflection.refl_z == '0), "degenerate result not zero")

endmodule

// ===== hw/rtl/rvu_norm.sv =====
// pipelined normaliser: scales a three-component vector to unit length
// depends on rvu_pkg; every stage advances only while ctrl.en is high
`timescale 1ns / 1ps
module rvu_norm (
	input  logic                clk,
	input  rvu_pkg::pipe_ctrl_t ctrl,
	input  rvu_pkg::comp_t      comp [3],
	output rvu_pkg::unit_t      unit_vec [3],
	output logic                zero
);

	localparam int RW      = rvu_pkg::SQ_BITS + 3;
	localparam int RAD_W   = 2 * rvu_pkg::SQ_BITS;
	localparam int NUM_SH  = rvu_pkg::OUT_FRAC_BITS + rvu_pkg::SQRT_FRAC;
	localparam int NUM_W   = rvu_pkg::PRE_W + NUM_SH + 1;
	localparam int DIV_W   = NUM_W + 1;
	localparam int ALIGN_W = rvu_pkg::MAG_W + rvu_pkg::PRE_W - 1;

	typedef struct packed {
		logic [RW-1:0]                        rem;
		logic [rvu_pkg::SQ_BITS-1:0]          root;
		logic [rvu_pkg::SUM_W-1:0]            sum;
		logic [2:0][rvu_pkg::PRE_W-1:0]       mag;
		logic [2:0]                           neg;
		logic                                 zero;
	} sq_t;

	typedef struct packed {
		logic [2:0][DIV_W-1:0]                rem;
		logic [2:0][rvu_pkg::QUO_W-1:0]       quo;
		logic [rvu_pkg::SQ_BITS-1:0]          den;
		logic [2:0]                           neg;
		logic                                 zero;
	} dv_t;

	// one root bit: bring down two radicand bits, trial subtract
	function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
		sq_t           nxt;
		logic [RW-1:0] r2;
		logic [RW-1:0] trial;
		nxt   = cur;
		r2    = {cur.rem[RW-3:0], pair};
		trial = RW'({cur.root, 2'b01});
		if (r2 >= trial) begin
			nxt.rem  = r2 - trial;
			nxt.root = {cur.root[rvu_pkg::SQ_BITS-2:0], 1'b1};
		end else begin
			nxt.rem  = r2;
			nxt.root = {cur.root[rvu_pkg::SQ_BITS-2:0], 1'b0};
		end
		return nxt;
	endfunction

	// radicand is sum * 2^(2*SQRT_FRAC); pair for the j-th root bit from the top
	function automatic logic [1:0] rad_pair(logic [rvu_pkg::SUM_W-1:0] s, int j);
		logic [RAD_W-1:0] rad;
		rad = {s, {(RAD_W - rvu_pkg::SUM_W){1'b0}}};
		return rad[2 * (rvu_pkg::SQ_BITS - 1 - j) +: 2];
	endfunction

	// one quotient bit for each component against the shared length
	function automatic dv_t div_step(dv_t cur, int j);
		dv_t              nxt;
		logic [DIV_W-1:0] dsh;
		int               k;
		nxt = cur;
		k   = rvu_pkg::QUO_W - 1 - j;
		dsh = DIV_W'(cur.den) << k;
		for (int i = 0; i < 3; i++) begin
			if (cur.rem[i] >= dsh) begin
				nxt.rem[i]    = cur.rem[i] - dsh;
				nxt.quo[i][k] = 1'b1;
			end
		end
		return nxt;
	endfunction

	logic [2:0][rvu_pkg::MAG_W-1:0]   mag_s1;
	logic [2:0]                       neg_s1;
	logic [2:0][rvu_pkg::PRE_W-1:0]   pre_s2, pre_s3, pre_s4;
	logic [2:0]                       neg_s2, neg_s3, neg_s4;
	logic                             zero_s2, zero_s3, zero_s4;
	logic [2:0][2*rvu_pkg::PRE_W-1:0] sq_s3;
	logic [rvu_pkg::SUM_W-1:0]        sum_s4;

	logic [rvu_pkg::MAG_W-1:0]        orm;
	logic [rvu_pkg::POS_W-1:0]        pos;
	logic [2:0][rvu_pkg::PRE_W-1:0]   pre;
	logic [ALIGN_W-1:0]               al;

	sq_t sqrt_in;
	sq_t sqrt_s [rvu_pkg::SQ_BITS];
	dv_t div_in;
	dv_t div_s [rvu_pkg::QUO_W + 1];

	// leading one of the or of all magnitudes is that of the largest
	always_comb begin
		orm = mag_s1[0] | mag_s1[1] | mag_s1[2];
		pos = '0;
		for (int b = 0; b < rvu_pkg::MAG_W; b++) begin
			if (orm[b]) begin
				pos = rvu_pkg::POS_W'(b);
			end
		end
		for (int i = 0; i < 3; i++) begin
			al     = {mag_s1[i], {(rvu_pkg::PRE_W - 1){1'b0}}};
			pre[i] = rvu_pkg::PRE_W'(al >> pos);
		end
	end

	always_comb begin
		sqrt_in      = '0;
		sqrt_in.sum  = sum_s4;
		sqrt_in.mag  = pre_s4;
		sqrt_in.neg  = neg_s4;
		sqrt_in.zero = zero_s4;
	end

	// numerator m * 2^(F+16) plus half the length, for round to nearest
	always_comb begin
		div_in      = '0;
		div_in.den  = sqrt_s[rvu_pkg::SQ_BITS-1].root;
		div_in.neg  = sqrt_s[rvu_pkg::SQ_BITS-1].neg;
		div_in.zero = sqrt_s[rvu_pkg::SQ_BITS-1].zero;
		for (int i = 0; i < 3; i++) begin
			div_in.rem[i] = DIV_W'({sqrt_s[rvu_pkg::SQ_BITS-1].mag[i], {NUM_SH{1'b0}}})
				+ DIV_W'(sqrt_s[rvu_pkg::SQ_BITS-1].root >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= comp[i][rvu_pkg::IN_WIDTH-1];
				mag_s1[i] <= comp[i][rvu_pkg::IN_WIDTH-1] ?
					rvu_pkg::MAG_W'(-comp[i]) : rvu_pkg::MAG_W'(comp[i]);
			end

			pre_s2  <= pre;
			neg_s2  <= neg_s1;
			zero_s2 <= (orm == '0);

			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= pre_s2[i] * pre_s2[i];
			end
			pre_s3  <= pre_s2;
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;

			sum_s4  <= rvu_pkg::SUM_W'(sq_s3[0]) + rvu_pkg::SUM_W'(sq_s3[1])
				+ rvu_pkg::SUM_W'(sq_s3[2]);
			pre_s4  <= pre_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;

			sqrt_s[0] <= sqrt_step(sqrt_in, rad_pair(sqrt_in.sum, 0));
			for (int j = 1; j < rvu_pkg::SQ_BITS; j++) begin
				sqrt_s[j] <= sqrt_step(sqrt_s[j-1], rad_pair(sqrt_s[j-1].sum, j));
			end

			div_s[0] <= div_in;
			for (int j = 1; j <= rvu_pkg::QUO_W; j++) begin
				div_s[j] <= div_step(div_s[j-1], j - 1);
			end

			for (int i = 0; i < 3; i++) begin
				unit_vec[i] <= div_s[rvu_pkg::QUO_W].neg[i] ?
					-rvu_pkg::UNIT_W'(div_s[rvu_pkg::QUO_W].quo[i]) :
					rvu_pkg::UNIT_W'(div_s[rvu_pkg::QUO_W].quo[i]);
			end
			zero <= div_s[rvu_pkg::QUO_W].zero;
		end
	end

endmodule
